// File: rtl/aabb_pkg.sv
// Package: widths and constants for the box overlap push-vector core.
package aabb_pkg;

	localparam int COORD_BITS_DEF = 16;
	localparam int PUSH_BITS      = 16;
	localparam int Q_BITS         = 15;      // magnitude 0..16384
	localparam int PUSH_ONE       = 16384;

endpackage

// File: rtl/aabb_front.sv
// Front stages: edge sums, overlap test and doubled centre differences.
module aabb_front import aabb_pkg::*; #(
	parameter int CB = COORD_BITS_DEF,
	localparam int DB = CB + 3
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_v,
	input  logic signed [CB-1:0] a_left,
	input  logic signed [CB-1:0] a_top,
	input  logic        [CB-2:0] a_width,
	input  logic        [CB-2:0] a_height,
	input  logic signed [CB-1:0] b_left,
	input  logic signed [CB-1:0] b_top,
	input  logic        [CB-2:0] b_width,
	input  logic        [CB-2:0] b_height,
	output logic                 v_s1,
	output logic                 hit_s1,
	output logic                 xneg_s1,
	output logic                 yneg_s1,
	output logic        [DB-1:0] adx_s1,
	output logic        [DB-1:0] ady_s1
);

	logic signed [CB+1:0] ar, br, ab, bb, al, bl, at, bt;
	logic signed [DB:0]   dx, dy;
	logic                 hx, hy;

	always_comb begin
		al = {{2{a_left[CB-1]}}, a_left};
		bl = {{2{b_left[CB-1]}}, b_left};
		at = {{2{a_top[CB-1]}}, a_top};
		bt = {{2{b_top[CB-1]}}, b_top};
		ar = al + $signed({3'b0, a_width});
		br = bl + $signed({3'b0, b_width});
		ab = at + $signed({3'b0, a_height});
		bb = bt + $signed({3'b0, b_height});
		hx = ((al > bl) ? al : bl) < ((ar < br) ? ar : br);
		hy = ((at > bt) ? at : bt) < ((ab < bb) ? ab : bb);
		dx = (DB+1)'(ar + al) - (DB+1)'(br + bl);
		dy = (DB+1)'(ab + at) - (DB+1)'(bb + bt);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_s1  <= hx && hy;
			xneg_s1 <= dx[DB];
			yneg_s1 <= dy[DB];
			adx_s1  <= dx[DB] ? DB'(-dx) : DB'(dx);
			ady_s1  <= dy[DB] ? DB'(-dy) : DB'(dy);
		end
	end

endmodule

// File: rtl/aabb_unit.sv
// Bit-serial pipelined search for the rounded unit components, one bit per stage.
module aabb_unit import aabb_pkg::*; #(
	parameter int CB = COORD_BITS_DEF,
	localparam int DB = CB + 3,
	localparam int SW = 2 * DB + 1,
	localparam int RW = 2 * DB + 30,
	localparam int NS = Q_BITS,
	localparam int PW = SW + 2 * Q_BITS,
	localparam int LNW = SW + Q_BITS,
	localparam int LW = SW + 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          v_i,
	input  logic          hit_i,
	input  logic          xneg_i,
	input  logic          yneg_i,
	input  logic [DB-1:0] adx_i,
	input  logic [DB-1:0] ady_i,
	output logic          v_o,
	output logic          hit_o,
	output logic signed [PUSH_BITS-1:0] push_x,
	output logic signed [PUSH_BITS-1:0] push_y
);

	// stage 0 squares, then one q bit per stage (MSB first), then output.
	// s*q^2 and s*q are carried along so each trial needs only shifts and adds.
	logic [SW-1:0]      s_s [NS+1];
	logic [RW-1:0]      rx_s [NS+1], ry_s [NS+1];
	logic [Q_BITS-1:0]  qx_s [NS+1], qy_s [NS+1];
	logic [PW-1:0]      sqx_s [NS+1], sqy_s [NS+1];
	logic [LNW-1:0]     slx_s [NS+1], sly_s [NS+1];
	logic               v_s [NS+1], hit_s [NS+1], xn_s [NS+1], yn_s [NS+1], nz_s [NS+1];
	logic [2*DB-1:0]    dx2, dy2;

	assign dx2 = adx_i * adx_i;
	assign dy2 = ady_i * ady_i;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= NS; i++) v_s[i] <= 1'b0;
		end else if (en) begin
			v_s[0] <= v_i;
			for (int i = 1; i <= NS; i++) v_s[i] <= v_s[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s_s[0]   <= SW'(dx2) + SW'(dy2);
			rx_s[0]  <= RW'(dx2) << 30;
			ry_s[0]  <= RW'(dy2) << 30;
			qx_s[0]  <= '0;
			qy_s[0]  <= '0;
			sqx_s[0] <= '0;
			sqy_s[0] <= '0;
			slx_s[0] <= '0;
			sly_s[0] <= '0;
			hit_s[0] <= hit_i;
			xn_s[0]  <= xneg_i;
			yn_s[0]  <= yneg_i;
			nz_s[0]  <= (adx_i != '0) || (ady_i != '0);
		end
	end

	// largest q with s*(2q-1)^2 <= rhs; q <= 16384 so 15 bits suffice
	// trial t = q + 2^B: s*(2t-1)^2 = 4*s*q^2 + 4*c*s*q + c^2*s, c = 2^(B+1)-1
	for (genvar g = 0; g < NS; g++) begin : g_bit
		localparam int B = Q_BITS - 1 - g;
		localparam int M = B + 1;
		logic [Q_BITS-1:0] tx, ty;
		logic [LW-1:0]     lx, ly;
		logic [PW-1:0]     nsqx, nsqy;
		logic [LNW-1:0]    nslx, nsly;
		logic              okx, oky;
		always_comb begin
			tx    = qx_s[g];
			ty    = qy_s[g];
			tx[B] = 1'b1;
			ty[B] = 1'b1;
			lx = (LW'(sqx_s[g]) << 2) + (LW'(slx_s[g]) << (M + 2)) - (LW'(slx_s[g]) << 2)
				+ (LW'(s_s[g]) << (2 * M)) - (LW'(s_s[g]) << (M + 1)) + LW'(s_s[g]);
			ly = (LW'(sqy_s[g]) << 2) + (LW'(sly_s[g]) << (M + 2)) - (LW'(sly_s[g]) << 2)
				+ (LW'(s_s[g]) << (2 * M)) - (LW'(s_s[g]) << (M + 1)) + LW'(s_s[g]);
			nsqx = sqx_s[g] + (PW'(slx_s[g]) << M) + (PW'(s_s[g]) << (2 * B));
			nsqy = sqy_s[g] + (PW'(sly_s[g]) << M) + (PW'(s_s[g]) << (2 * B));
			nslx = slx_s[g] + (LNW'(s_s[g]) << B);
			nsly = sly_s[g] + (LNW'(s_s[g]) << B);
			okx = (tx <= Q_BITS'(PUSH_ONE)) && (lx <= LW'(rx_s[g]));
			oky = (ty <= Q_BITS'(PUSH_ONE)) && (ly <= LW'(ry_s[g]));
		end
		always_ff @(posedge clk) begin
			if (en) begin
				s_s[g+1]   <= s_s[g];
				rx_s[g+1]  <= rx_s[g];
				ry_s[g+1]  <= ry_s[g];
				qx_s[g+1]  <= okx ? tx : qx_s[g];
				qy_s[g+1]  <= oky ? ty : qy_s[g];
				sqx_s[g+1] <= okx ? nsqx : sqx_s[g];
				sqy_s[g+1] <= oky ? nsqy : sqy_s[g];
				slx_s[g+1] <= okx ? nslx : slx_s[g];
				sly_s[g+1] <= oky ? nsly : sly_s[g];
				hit_s[g+1] <= hit_s[g];
				xn_s[g+1]  <= xn_s[g];
				yn_s[g+1]  <= yn_s[g];
				nz_s[g+1]  <= nz_s[g];
			end
		end
	end

	logic [PUSH_BITS-1:0] mx, my;
	assign mx = (hit_s[NS] && nz_s[NS]) ? PUSH_BITS'(qx_s[NS]) : '0;
	assign my = (hit_s[NS] && nz_s[NS]) ? PUSH_BITS'(qy_s[NS]) : '0;

	assign v_o    = v_s[NS];
	assign hit_o  = hit_s[NS];
	assign push_x = xn_s[NS] ? -mx : mx;
	assign push_y = yn_s[NS] ? -my : my;

endmodule

// File: rtl/aabb_overlap_push_vector_core.sv
// Top level: box overlap test with unit push vector, valid/ready pipeline.
// Pipeline registers from input transfer to result: front, squares, 15 search stages.
// Throughput: one pair per cycle; the whole pipe advances when the output is free.
// Result register sits at the end of the search pipe; a stall holds every stage.
// Reset (arst_n low) clears all valid bits; payload registers are not reset.
module aabb_overlap_push_vector_core import aabb_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [COORD_BITS-1:0] a_left,
	input  logic signed [COORD_BITS-1:0] a_top,
	input  logic        [COORD_BITS-2:0] a_width,
	input  logic        [COORD_BITS-2:0] a_height,
	input  logic signed [COORD_BITS-1:0] b_left,
	input  logic signed [COORD_BITS-1:0] b_top,
	input  logic        [COORD_BITS-2:0] b_width,
	input  logic        [COORD_BITS-2:0] b_height,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         hit,
	output logic signed [PUSH_BITS-1:0]  push_x,
	output logic signed [PUSH_BITS-1:0]  push_y
);

	localparam int DB = COORD_BITS + 3;

	logic          en, v_s1, hit_s1, xn_s1, yn_s1;
	logic [DB-1:0] adx_s1, ady_s1;

	assign en       = out_ready || !out_valid;
	assign in_ready = en;

	aabb_front #(.CB(COORD_BITS)) u_front (
		.clk, .arst_n, .en, .in_v(in_valid),
		.a_left, .a_top, .a_width, .a_height,
		.b_left, .b_top, .b_width, .b_height,
		.v_s1, .hit_s1, .xneg_s1(xn_s1), .yneg_s1(yn_s1),
		.adx_s1, .ady_s1
	);

	aabb_unit #(.CB(COORD_BITS)) u_unit (
		.clk, .arst_n, .en, .v_i(v_s1), .hit_i(hit_s1),
		.xneg_i(xn_s1), .yneg_i(yn_s1), .adx_i(adx_s1), .ady_i(ady_s1),
		.v_o(out_valid), .hit_o(hit), .push_x, .push_y
	);

	a_no_push_miss: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> push_x == '0 && push_y == '0)
		else $error("push vector set without a hit");
	a_range_x: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> push_x <= 16'sd16384 && push_x >= -16'sd16384)
		else $error("push_x out of range");
	a_range_y: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> push_y <= 16'sd16384 && push_y >= -16'sd16384)
		else $error("push_y out of range");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(hit))
		else $error("stalled result changed");

endmodule

// File: bench/tb_aabb_overlap_push_vector_core.sv
// Testbench for the box overlap push-vector core: self-checking, random stalls on both sides.
module tb_aabb_overlap_push_vector_core;
	import aabb_pkg::*;

	localparam int CB        = COORD_BITS_DEF;
	localparam int LIMIT     = 400000;
	localparam int N_RANDOM  = 1500;
	localparam int HOLD_LEN  = 300;

	typedef struct {
		logic signed [CB-1:0] al, at, bl, bt;
		logic [CB-2:0] aw, ah, bw, bh;
	} box_pair_t;

	typedef struct {
		logic hit;
		logic signed [PUSH_BITS-1:0] px, py;
	} push_result_t;

	class push_scoreboard;
		push_result_t pending_q[$];
		int mismatches = 0;

		// nearest q to d * 2^14 / sqrt(s), ties away from zero
		function automatic logic [15:0] unit_mag(logic [63:0] d, logic [79:0] s);
			logic [79:0] rhs, lhs;
			logic [63:0] k;
			int lo, hi, q;
			rhs = ({16'd0, d} * {16'd0, d}) << 30;
			lo = 0;
			hi = PUSH_ONE;
			while (lo < hi) begin
				q = (lo + hi + 1) >> 1;
				k = 2 * q - 1;
				lhs = s * {16'd0, k * k};
				if (lhs <= rhs) lo = q;
				else hi = q - 1;
			end
			return lo[15:0];
		endfunction

		function void note_pair(box_pair_t p);
			push_result_t r;
			longint al, at, aw, ah, bl, bt, bw, bh, x0, x1, y0, y1, dx, dy;
			logic [63:0] adx, ady;
			logic [79:0] s;
			logic [15:0] qx, qy;
			al = p.al; at = p.at; bl = p.bl; bt = p.bt;
			aw = p.aw; ah = p.ah; bw = p.bw; bh = p.bh;
			x0 = al > bl ? al : bl;
			x1 = (al + aw) < (bl + bw) ? al + aw : bl + bw;
			y0 = at > bt ? at : bt;
			y1 = (at + ah) < (bt + bh) ? at + ah : bt + bh;
			r.hit = (x0 < x1) && (y0 < y1);
			r.px = '0;
			r.py = '0;
			if (r.hit) begin
				dx = (2 * al + aw) - (2 * bl + bw);
				dy = (2 * at + ah) - (2 * bt + bh);
				if (dx != 0 || dy != 0) begin
					adx = dx < 0 ? -dx : dx;
					ady = dy < 0 ? -dy : dy;
					s = {16'd0, adx} * {16'd0, adx} + {16'd0, ady} * {16'd0, ady};
					qx = unit_mag(adx, s);
					qy = unit_mag(ady, s);
					r.px = dx < 0 ? -qx : qx;
					r.py = dy < 0 ? -qy : qy;
				end
			end
			pending_q.push_back(r);
		endfunction

		function void check_result(logic h, logic signed [PUSH_BITS-1:0] x,
				logic signed [PUSH_BITS-1:0] y);
			push_result_t e;
			if (pending_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result transfer: hit=%0d x=%0d y=%0d", h, x, y);
				return;
			end
			e = pending_q.pop_front();
			if (h !== e.hit || x !== e.px || y !== e.py) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: exp hit=%0d x=%0d y=%0d, got hit=%0d x=%0d y=%0d",
						e.hit, e.px, e.py, h, x, y);
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready;
	logic signed [CB-1:0] a_left, a_top, b_left, b_top;
	logic [CB-2:0] a_width, a_height, b_width, b_height;
	logic hit;
	logic signed [PUSH_BITS-1:0] push_x, push_y;

	push_scoreboard sb;
	int tx_idle_pct, rx_idle_pct;
	bit hold_req;
	int cycles;

	aabb_overlap_push_vector_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.a_left(a_left), .a_top(a_top), .a_width(a_width), .a_height(a_height),
		.b_left(b_left), .b_top(b_top), .b_width(b_width), .b_height(b_height),
		.out_valid(out_valid), .out_ready(out_ready),
		.hit(hit), .push_x(push_x), .push_y(push_y)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("** aabb_overlap_push_vector_core: FAILED **");
			$finish;
		end
	end

	// receiver: random stalls, plus a long hold-off on request
	initial begin
		int hold_cnt;
		out_ready = 0;
		hold_cnt = 0;
		forever begin
			@(negedge clk);
			if (hold_req && hold_cnt == 0) hold_cnt = HOLD_LEN;
			if (hold_cnt > 0) begin
				hold_cnt--;
				if (hold_cnt == 0) hold_req = 0;
				out_ready = 0;
			end else begin
				out_ready = ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	always @(posedge clk)
		if (arst_n && out_valid && out_ready) sb.check_result(hit, push_x, push_y);

	task automatic send_pair(box_pair_t p);
		@(negedge clk);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid = 0;
			@(negedge clk);
		end
		in_valid = 1;
		a_left = p.al; a_top = p.at; a_width = p.aw; a_height = p.ah;
		b_left = p.bl; b_top = p.bt; b_width = p.bw; b_height = p.bh;
		do @(posedge clk); while (!in_ready);
		sb.note_pair(p);
	endtask

	task automatic drain_pairs();
		@(negedge clk);
		in_valid = 0;
		while (sb.pending_q.size() != 0) @(posedge clk);
	endtask

	function automatic box_pair_t mk(int al, int at, int aw, int ah,
			int bl, int bt, int bw, int bh);
		box_pair_t p;
		p.al = CB'(al); p.at = CB'(at); p.aw = (CB-1)'(aw); p.ah = (CB-1)'(ah);
		p.bl = CB'(bl); p.bt = CB'(bt); p.bw = (CB-1)'(bw); p.bh = (CB-1)'(bh);
		return p;
	endfunction

	// mostly overlapping pairs with small sizes; the rest fully random
	function automatic box_pair_t rand_pair();
		box_pair_t p;
		if ($urandom_range(99) < 30) begin
			p = mk($urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom, $urandom);
		end else begin
			p.bl = CB'($urandom); p.bt = CB'($urandom);
			p.bw = (CB-1)'($urandom_range(0, 3000)); p.bh = (CB-1)'($urandom_range(0, 3000));
			p.aw = (CB-1)'($urandom_range(0, 3000)); p.ah = (CB-1)'($urandom_range(0, 3000));
			p.al = CB'(p.bl + $signed($urandom_range(0, 6000)) - 3000);
			p.at = CB'(p.bt + $signed($urandom_range(0, 6000)) - 3000);
		end
		return p;
	endfunction

	initial begin
		box_pair_t dir_q[$];
		sb = new();
		cycles = 0;
		hold_req = 0;
		tx_idle_pct = 21;
		rx_idle_pct = 77;
		in_valid = 0;
		a_left = 0; a_top = 0; a_width = 0; a_height = 0;
		b_left = 0; b_top = 0; b_width = 0; b_height = 0;
		arst_n = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// extremes, no hit, zero size, coinciding centres, axis-aligned pushes
		dir_q.push_back(mk(0, 0, 16, 16, 0, 0, 16, 16));
		dir_q.push_back(mk(-32768, -32768, 32767, 32767, -32768, -32768, 32767, 32767));
		dir_q.push_back(mk(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
		dir_q.push_back(mk(-32768, -32768, 32767, 32767, 32767, 32767, 32767, 32767));
		dir_q.push_back(mk(-32768, 0, 32767, 100, 0, 0, 32767, 100));
		dir_q.push_back(mk(0, 0, 0, 16, 0, 0, 16, 16));
		dir_q.push_back(mk(0, 0, 16, 0, 0, 0, 16, 16));
		dir_q.push_back(mk(0, 0, 16, 16, 16, 0, 16, 16));
		dir_q.push_back(mk(0, 0, 16, 16, 15, 0, 16, 16));
		dir_q.push_back(mk(0, 0, 16, 16, 0, 15, 16, 16));
		dir_q.push_back(mk(0, 0, 16, 16, -15, -15, 16, 16));
		dir_q.push_back(mk(10, 10, 10, 10, 0, 0, 30, 30));
		dir_q.push_back(mk(0, 0, 100, 100, 3, 4, 100, 100));
		dir_q.push_back(mk(0, 0, 100, 100, -4, 3, 100, 100));
		dir_q.push_back(mk(-100, -200, 500, 400, 50, 20, 300, 200));
		dir_q.push_back(mk(0, 0, 32767, 32767, 1, 1, 1, 1));
		dir_q.push_back(mk(32767, -32768, 1, 1, 32767, -32768, 1, 1));
		dir_q.push_back(mk(0, 0, 1, 1, 1, 1, 1, 1));
		dir_q.push_back(mk(5, 0, 1, 32767, 0, 0, 32767, 1));
		foreach (dir_q[i]) send_pair(dir_q[i]);
		drain_pairs();

		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == N_RANDOM / 3) begin
				tx_idle_pct = 77;
				rx_idle_pct = 21;
			end
			if (i == 2 * N_RANDOM / 3) begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
				hold_req = 1;
			end
			if (i == N_RANDOM / 2) drain_pairs();
			send_pair(rand_pair());
		end
		drain_pairs();
		repeat (30) @(posedge clk);

		if (sb.mismatches == 0 && sb.pending_q.size() == 0)
			$display("** aabb_overlap_push_vector_core: PASSED **");
		else
			$display("** aabb_overlap_push_vector_core: FAILED **");
		$finish;
	end

endmodule
